@@ hw/rtl/dcgn_pkg.sv @@
// ----------------------------------------------------------------------------
// dcgn_pkg
// Shared widths, constants and types for the diamond-cell gradient norm block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcgn_pkg;

   // Pixel and register widths
   localparam int DATA_W  = 16;
   localparam int INV_W   = 16;
   localparam int EPS_W   = 32;
   localparam int NORM_W  = 16;
   localparam int CSR_W   = 32;

   // Magnitudes of the edge differences
   localparam int ALONG_W = 16;   // |a - b| of two Q4.12 pixels
   localparam int CROSS_W = 17;   // |a + b - c - d| of four Q4.12 pixels

   // Component clamp at 16.0 in Q.22
   localparam int COMP_W = 27;
   localparam logic [COMP_W-1:0] COMP_LIMIT = COMP_W'(1) << (COMP_W - 1);

   // Squares, sum and radicand
   localparam int SQ_W    = 2 * COMP_W;
   localparam int SUM_W   = SQ_W + 1;
   localparam int SHIFT   = 20;
   localparam int RAD_W   = 2 * NORM_W;
   localparam int RADX_W  = SUM_W - SHIFT + 1;
   localparam int REM_W   = NORM_W + 2;

   // Pipeline depth
   localparam int SQRT_STAGES = NORM_W;
   localparam int FRONT_STAGES = 4;   // operand, scale, square, sum
   localparam int LATENCY = FRONT_STAGES + SQRT_STAGES + 1;

   // Configuration registers
   typedef enum logic [0:0] {
      CSR_INV_SPACING = 1'b0,
      CSR_EPSILON     = 1'b1
   } csr_index_type;

   localparam logic [INV_W-1:0] INV_RESET = INV_W'(256);
   localparam logic [EPS_W-1:0] EPS_RESET = '0;

   // Operands of one edge
   typedef struct packed {
      logic [ALONG_W-1:0] along_mag;
      logic [CROSS_W-1:0] cross_mag;
   } edge_operand_type;

   // Result of one edge
   typedef struct packed {
      logic [NORM_W-1:0] norm;
      logic              clip;
   } edge_result_type;

endpackage

@@ hw/rtl/dcgn_edge_norm.sv @@
// ----------------------------------------------------------------------------
// dcgn_edge_norm
// One edge lane: scale and clamp both components, square, add epsilon, then
// a one-bit-per-stage integer square root with clipping to the output range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcgn_edge_norm
   import dcgn_pkg::*;
(
   input  logic             clock,
   input  edge_operand_type operand,
   input  logic [INV_W-1:0] inv_spacing,
   input  logic [EPS_W-1:0] epsilon,
   output edge_result_type  result
);

   // Scale stage: along * inv * 4 and cross * inv, clamped at 16.0
   logic [2*INV_W-1:0]       a_prod;
   logic [2*INV_W+1:0]       a_scaled;
   logic [CROSS_W+INV_W-1:0] c_prod;
   logic [COMP_W-1:0]        a_comp_in, a_comp_ff;
   logic [COMP_W-1:0]        c_comp_in, c_comp_ff;

   always_comb begin
      a_prod    = operand.along_mag * inv_spacing;
      a_scaled  = {a_prod, 2'b00};
      c_prod    = operand.cross_mag * inv_spacing;
      a_comp_in = (a_scaled > (2*INV_W+2)'(COMP_LIMIT)) ? COMP_LIMIT
                                                        : a_scaled[COMP_W-1:0];
      c_comp_in = (c_prod > (CROSS_W+INV_W)'(COMP_LIMIT)) ? COMP_LIMIT
                                                           : c_prod[COMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      a_comp_ff <= a_comp_in;
      c_comp_ff <= c_comp_in;
   end

   // Square stage
   logic [SQ_W-1:0] a_sq_in, a_sq_ff;
   logic [SQ_W-1:0] c_sq_in, c_sq_ff;

   assign a_sq_in = a_comp_ff * a_comp_ff;
   assign c_sq_in = c_comp_ff * c_comp_ff;

   always_ff @(posedge clock) begin
      a_sq_ff <= a_sq_in;
      c_sq_ff <= c_sq_in;
   end

   // Sum stage: floor((a^2 + c^2) / 2^20) + epsilon; clip when root >= 2^16
   logic [SUM_W-1:0]  sq_sum;
   logic [RADX_W-1:0] rad_full;
   logic [RAD_W-1:0]  rad_in, rad_ff;
   logic              over_in, over_ff;

   always_comb begin
      sq_sum   = {1'b0, a_sq_ff} + {1'b0, c_sq_ff};
      rad_full = {1'b0, sq_sum[SUM_W-1:SHIFT]} + RADX_W'(epsilon);
      rad_in   = rad_full[RAD_W-1:0];
      over_in  = |rad_full[RADX_W-1:RAD_W];
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      over_ff <= over_in;
   end

   // Square root pipeline, one root bit per stage
   logic [REM_W-1:0]  rem_src  [SQRT_STAGES];
   logic [NORM_W-1:0] root_src [SQRT_STAGES];
   logic [RAD_W-1:0]  bits_src [SQRT_STAGES];
   logic              clip_src [SQRT_STAGES];
   logic [REM_W-1:0]  rem_ff   [SQRT_STAGES];
   logic [NORM_W-1:0] root_ff  [SQRT_STAGES];
   logic [RAD_W-1:0]  bits_ff  [SQRT_STAGES];
   logic              clip_ff  [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      logic [REM_W+1:0]  cur_rem;
      logic [REM_W+1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [NORM_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_src[k]  = '0;
         assign root_src[k] = '0;
         assign bits_src[k] = rad_ff;
         assign clip_src[k] = over_ff;
      end else begin : g_next
         assign rem_src[k]  = rem_ff[k-1];
         assign root_src[k] = root_ff[k-1];
         assign bits_src[k] = bits_ff[k-1];
         assign clip_src[k] = clip_ff[k-1];
      end

      // Bring down two radicand bits, try root*4+1
      always_comb begin
         cur_rem = {rem_src[k], bits_src[k][RAD_W-1 -: 2]};
         trial   = {2'b00, root_src[k], 2'b01};
         if (cur_rem >= trial) begin
            rem_in  = REM_W'(cur_rem - trial);
            root_in = {root_src[k][NORM_W-2:0], 1'b1};
         end else begin
            rem_in  = cur_rem[REM_W-1:0];
            root_in = {root_src[k][NORM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         bits_ff[k] <= {bits_src[k][RAD_W-3:0], 2'b00};
         clip_ff[k] <= clip_src[k];
      end
   end

   // Clip to full scale
   assign result.clip = clip_ff[SQRT_STAGES-1];
   assign result.norm = clip_ff[SQRT_STAGES-1] ? '1 : root_ff[SQRT_STAGES-1];

endmodule

@@ hw/rtl/diamond_cell_gradient_norms_top.sv @@
// ----------------------------------------------------------------------------
// diamond_cell_gradient_norms_top
// Regularized gradient norms on the four diamond-cell edges of a 3x3 window.
// Throughput: one window per cycle; busy stays low, so start may be held high.
// The 16-stage bit-per-stage square root sets most of the depth.
// Reset clears the valid pipeline; inv_spacing returns to 1.0, epsilon to 0.
// Results come out as single-cycle rsp_valid beats; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diamond_cell_gradient_norms_top
   import dcgn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_center,
   input  logic signed [DATA_W-1:0] req_east,
   input  logic signed [DATA_W-1:0] req_west,
   input  logic signed [DATA_W-1:0] req_north,
   input  logic signed [DATA_W-1:0] req_south,
   input  logic signed [DATA_W-1:0] req_north_east,
   input  logic signed [DATA_W-1:0] req_north_west,
   input  logic signed [DATA_W-1:0] req_south_east,
   input  logic signed [DATA_W-1:0] req_south_west,
   // Configuration port
   input  logic                     csr_write,
   input  logic [0:0]               csr_index,
   input  logic [CSR_W-1:0]         csr_wdata,
   // Response channel
   output logic                     rsp_valid,
   output logic [NORM_W-1:0]        rsp_grad_east,
   output logic [NORM_W-1:0]        rsp_grad_west,
   output logic [NORM_W-1:0]        rsp_grad_north,
   output logic [NORM_W-1:0]        rsp_grad_south,
   output logic                     rsp_saturated
);

   localparam int EDGES = 4;

   // Fully pipelined, never busy
   logic req_accept;
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   // Configuration registers
   logic [INV_W-1:0] inv_spacing_ff;
   logic [EPS_W-1:0] epsilon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_spacing_ff <= INV_RESET;
         epsilon_ff     <= EPS_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_INV_SPACING: inv_spacing_ff <= csr_wdata[INV_W-1:0];
            CSR_EPSILON:     epsilon_ff     <= csr_wdata[EPS_W-1:0];
         endcase
      end
   end

   // Edge differences: along in 17 bits, cross in 18 bits, returned as 16- and 17-bit magnitudes
   function automatic logic [ALONG_W-1:0] along_mag(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b);
      logic [DATA_W:0] d;
      d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      return d[DATA_W] ? ALONG_W'(-d) : ALONG_W'(d);
   endfunction

   function automatic logic [CROSS_W-1:0] cross_mag(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b,
                                                    input logic [DATA_W-1:0] c,
                                                    input logic [DATA_W-1:0] d);
      logic [DATA_W+1:0] s;
      s = {{2{a[DATA_W-1]}}, a} + {{2{b[DATA_W-1]}}, b}
        - {{2{c[DATA_W-1]}}, c} - {{2{d[DATA_W-1]}}, d};
      return s[DATA_W+1] ? CROSS_W'(-s) : CROSS_W'(s);
   endfunction

   // Operand stage
   edge_operand_type operand_in [EDGES];
   edge_operand_type operand_ff [EDGES];

   always_comb begin
      // east
      operand_in[0].along_mag = along_mag(req_east, req_center);
      operand_in[0].cross_mag = cross_mag(req_north_east, req_north,
                                          req_south, req_south_east);
      // west
      operand_in[1].along_mag = along_mag(req_center, req_west);
      operand_in[1].cross_mag = cross_mag(req_north_west, req_north,
                                          req_south_west, req_south);
      // north
      operand_in[2].along_mag = along_mag(req_north, req_center);
      operand_in[2].cross_mag = cross_mag(req_north_east, req_east,
                                          req_north_west, req_west);
      // south
      operand_in[3].along_mag = along_mag(req_center, req_south);
      operand_in[3].cross_mag = cross_mag(req_south_east, req_east,
                                          req_south_west, req_west);
   end

   always_ff @(posedge clock) begin
      operand_ff <= operand_in;
   end

   // Edge lanes
   edge_result_type edge_result [EDGES];

   for (genvar e = 0; e < EDGES; e++) begin : g_edge
      dcgn_edge_norm u_edge (
         .clock       (clock),
         .operand     (operand_ff[e]),
         .inv_spacing (inv_spacing_ff),
         .epsilon     (epsilon_ff),
         .result      (edge_result[e])
      );
   end

   // Valid bits run alongside the data
   logic valid_ff [LATENCY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LATENCY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= req_accept;
         for (int i = 1; i < LATENCY; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Output register
   logic [NORM_W-1:0] grad_east_ff, grad_west_ff, grad_north_ff, grad_south_ff;
   logic              saturated_ff;

   always_ff @(posedge clock) begin
      grad_east_ff  <= edge_result[0].norm;
      grad_west_ff  <= edge_result[1].norm;
      grad_north_ff <= edge_result[2].norm;
      grad_south_ff <= edge_result[3].norm;
      saturated_ff  <= edge_result[0].clip | edge_result[1].clip
                     | edge_result[2].clip | edge_result[3].clip;
   end

   assign rsp_valid      = valid_ff[LATENCY-1];
   assign rsp_grad_east  = grad_east_ff;
   assign rsp_grad_west  = grad_west_ff;
   assign rsp_grad_north = grad_north_ff;
   assign rsp_grad_south = grad_south_ff;
   assign rsp_saturated  = saturated_ff;

   // Every response beat traces back to a start beat a full latency earlier
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, LATENCY))
      else $error("response without matching request");

   // A saturated response carries at least one full-scale norm
   a_sat_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_grad_east == '1 || rsp_grad_west == '1 ||
          rsp_grad_north == '1 || rsp_grad_south == '1))
      else $error("saturated flag without a clipped norm");

   // Reset empties the pipeline
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   // Zero spacing leaves only epsilon; equal lanes then
   a_zero_spacing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(inv_spacing_ff == '0, LATENCY)
                 && $stable(epsilon_ff)) |->
         (rsp_grad_east == rsp_grad_west && rsp_grad_north == rsp_grad_south
          && rsp_grad_east == rsp_grad_north))
      else $error("lanes differ with zero spacing");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the diamond-cell gradient norm block against a bit-exact predictor of
// its edge norms (all four) and clip flag. Directed corners come first, then
// random windows under a series of spacing and epsilon settings, with random
// start gaps. Each response beat is compared with the oldest queued prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// One 3x3 window as the request ports carry it, center first
typedef struct packed {
   logic signed [dcgn_pkg::DATA_W-1:0] center;
   logic signed [dcgn_pkg::DATA_W-1:0] east;
   logic signed [dcgn_pkg::DATA_W-1:0] west;
   logic signed [dcgn_pkg::DATA_W-1:0] north;
   logic signed [dcgn_pkg::DATA_W-1:0] south;
   logic signed [dcgn_pkg::DATA_W-1:0] north_east;
   logic signed [dcgn_pkg::DATA_W-1:0] north_west;
   logic signed [dcgn_pkg::DATA_W-1:0] south_east;
   logic signed [dcgn_pkg::DATA_W-1:0] south_west;
} window_type;

// The edge norms (all four) and the clip flag of a response beat
typedef struct packed {
   logic [dcgn_pkg::NORM_W-1:0] east;
   logic [dcgn_pkg::NORM_W-1:0] west;
   logic [dcgn_pkg::NORM_W-1:0] north;
   logic [dcgn_pkg::NORM_W-1:0] south;
   logic                        saturated;
} norms_type;

// ----------------------------------------------------------------------------
// Norm predictor and queue of expected response beats
// ----------------------------------------------------------------------------
class gradient_scoreboard;
   norms_type       expected_norms_q[$];
   longint unsigned inv_spacing;
   longint unsigned epsilon;
   int              errors;

   function new();
      inv_spacing = 64'(dcgn_pkg::INV_RESET);
      epsilon     = 64'(dcgn_pkg::EPS_RESET);
      errors      = 0;
   endfunction

   function void set_register(dcgn_pkg::csr_index_type idx,
                              logic [dcgn_pkg::CSR_W-1:0] value);
      case (idx)
         dcgn_pkg::CSR_INV_SPACING: inv_spacing = 64'(value[dcgn_pkg::INV_W-1:0]);
         dcgn_pkg::CSR_EPSILON:     epsilon     = 64'(value[dcgn_pkg::EPS_W-1:0]);
         default: ;
      endcase
   endfunction

   // |v|, held at 16.0 in Q.22
   function longint unsigned clamped_mag(longint v);
      longint unsigned cap;
      longint unsigned mag;
      cap = 64'd1 << (dcgn_pkg::COMP_W - 1);
      mag = (v < 0) ? -v : v;
      return (mag > cap) ? cap : mag;
   endfunction

   // floor(sqrt(x)), x stays below 2^36 here
   function longint unsigned floor_root(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 20; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= x)
            root = trial;
      end
      return root;
   endfunction

   // One edge: along scaled by 4/h, cross by 1/h, both Q.22
   function logic [dcgn_pkg::NORM_W-1:0] side_norm(longint along, longint cross_diff,
                                                   inout bit clipped);
      longint          inv;
      longint unsigned a;
      longint unsigned c;
      longint unsigned radicand;
      longint unsigned root;
      longint unsigned norm_max;
      norm_max = (64'd1 << dcgn_pkg::NORM_W) - 1;
      inv      = longint'(inv_spacing);
      a        = clamped_mag(along * inv * 4);
      c        = clamped_mag(cross_diff * inv);
      radicand = a * a + c * c + (epsilon << 20);
      root     = floor_root(radicand >> 20);
      if (root > norm_max) begin
         clipped = 1'b1;
         root    = norm_max;
      end
      return root[dcgn_pkg::NORM_W-1:0];
   endfunction

   function norms_type predict(window_type w);
      longint p, e, wv, n, s, ne, nw, se, sw;
      norms_type r;
      bit        clipped;
      p  = longint'(w.center);
      e  = longint'(w.east);
      wv = longint'(w.west);
      n  = longint'(w.north);
      s  = longint'(w.south);
      ne = longint'(w.north_east);
      nw = longint'(w.north_west);
      se = longint'(w.south_east);
      sw = longint'(w.south_west);
      clipped = 1'b0;
      r.east  = side_norm(e - p,  ne + n - s - se,  clipped);
      r.west  = side_norm(p - wv, nw + n - sw - s,  clipped);
      r.north = side_norm(n - p,  ne + e - nw - wv, clipped);
      r.south = side_norm(p - s,  se + e - sw - wv, clipped);
      r.saturated = clipped;
      return r;
   endfunction

   function void note_window(window_type w);
      expected_norms_q.push_back(predict(w));
   endfunction

   task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
   endtask

   task compare_field(string name, logic [dcgn_pkg::NORM_W-1:0] got,
                      logic [dcgn_pkg::NORM_W-1:0] want);
      if (got !== want)
         report($sformatf("%s got %h expected %h", name, got, want));
   endtask

   task check_norms(norms_type got);
      norms_type want;
      if (expected_norms_q.size() == 0) begin
         report($sformatf("response beat with nothing pending: %h", got));
         return;
      end
      want = expected_norms_q.pop_front();
      compare_field("grad_east",  got.east,  want.east);
      compare_field("grad_west",  got.west,  want.west);
      compare_field("grad_north", got.north, want.north);
      compare_field("grad_south", got.south, want.south);
      compare_field("saturated",  dcgn_pkg::NORM_W'(got.saturated),
                    dcgn_pkg::NORM_W'(want.saturated));
   endtask
endclass

module tb;
   import dcgn_pkg::*;

   localparam int WINDOWS_PER_SETTING = 190;
   localparam int SETTING_COUNT       = 8;
   localparam int CYCLE_LIMIT         = 100000;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [DATA_W-1:0] req_center;
   logic signed [DATA_W-1:0] req_east;
   logic signed [DATA_W-1:0] req_west;
   logic signed [DATA_W-1:0] req_north;
   logic signed [DATA_W-1:0] req_south;
   logic signed [DATA_W-1:0] req_north_east;
   logic signed [DATA_W-1:0] req_north_west;
   logic signed [DATA_W-1:0] req_south_east;
   logic signed [DATA_W-1:0] req_south_west;
   logic                     csr_write;
   logic [0:0]               csr_index;
   logic [CSR_W-1:0]         csr_wdata;
   logic                     rsp_valid;
   logic [NORM_W-1:0]        rsp_grad_east;
   logic [NORM_W-1:0]        rsp_grad_west;
   logic [NORM_W-1:0]        rsp_grad_north;
   logic [NORM_W-1:0]        rsp_grad_south;
   logic                     rsp_saturated;

   gradient_scoreboard norms_board = new();
   int                 sent_count  = 0;
   int                 cycle_count = 0;

   diamond_cell_gradient_norms_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_center     (req_center),
      .req_east       (req_east),
      .req_west       (req_west),
      .req_north      (req_north),
      .req_south      (req_south),
      .req_north_east (req_north_east),
      .req_north_west (req_north_west),
      .req_south_east (req_south_east),
      .req_south_west (req_south_west),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_grad_east  (rsp_grad_east),
      .rsp_grad_west  (rsp_grad_west),
      .rsp_grad_north (rsp_grad_north),
      .rsp_grad_south (rsp_grad_south),
      .rsp_saturated  (rsp_saturated)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Monitors: accepted start beats and response beats
   always @(posedge clock) begin
      if (!reset && start && !busy)
         norms_board.note_window({req_center, req_east, req_west, req_north,
                                  req_south, req_north_east, req_north_west,
                                  req_south_east, req_south_west});
      if (!reset && rsp_valid)
         norms_board.check_norms({rsp_grad_east, rsp_grad_west, rsp_grad_north,
                                  rsp_grad_south, rsp_saturated});
   end

   function automatic logic signed [DATA_W-1:0] clip_pixel(int v);
      if (v > 32767)
         return 16'sh7FFF;
      if (v < -32768)
         return 16'sh8000;
      return v[DATA_W-1:0];
   endfunction

   function automatic window_type make_window(int c, int e, int w, int n, int s,
                                              int ne, int nw, int se, int sw);
      return {clip_pixel(c), clip_pixel(e), clip_pixel(w), clip_pixel(n),
              clip_pixel(s), clip_pixel(ne), clip_pixel(nw), clip_pixel(se),
              clip_pixel(sw)};
   endfunction

   // Mostly smooth patches with a random slope scale, then raw noise and rails
   function automatic window_type random_window();
      logic [8:0][DATA_W-1:0] pix;
      int kind;
      int base;
      int spread;
      kind   = $urandom_range(0, 99);
      base   = int'($urandom_range(0, 65535)) - 32768;
      spread = 1 << $urandom_range(0, 14);
      for (int k = 0; k < 9; k++) begin
         if (kind < 55)
            pix[k] = clip_pixel(base + int'($urandom_range(0, 2 * spread)) - spread);
         else if (kind < 85)
            pix[k] = DATA_W'($urandom_range(0, 65535));
         else begin
            case ($urandom_range(0, 3))
               0:       pix[k] = 16'h8000;
               1:       pix[k] = 16'h7FFF;
               2:       pix[k] = 16'h0000;
               default: pix[k] = 16'hFFFF;
            endcase
         end
      end
      return window_type'(pix);
   endfunction

   // Drive one window; start stays high for back-to-back beats
   task automatic put_window(window_type w);
      int idle_pct;
      idle_pct = (sent_count < 500) ? 29 : (sent_count < 1000) ? 76 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      {req_center, req_east, req_west, req_north, req_south, req_north_east,
       req_north_west, req_south_east, req_south_west} <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sent_count++;
   endtask

   // Stop sending and wait until every predicted beat has come back; the first
   // edge lets the monitor log a beat accepted at the edge just taken
   task automatic wait_drained(int extra_cycles);
      start <= 1'b0;
      @(posedge clock);
      while (norms_board.expected_norms_q.size() != 0)
         @(posedge clock);
      repeat (extra_cycles)
         @(posedge clock);
   endtask

   // Write both registers while idle
   task automatic program_setting(logic [CSR_W-1:0] inv, logic [CSR_W-1:0] eps);
      csr_write <= 1'b1;
      csr_index <= CSR_INV_SPACING;
      csr_wdata <= inv;
      @(posedge clock);
      csr_index <= CSR_EPSILON;
      csr_wdata <= eps;
      @(posedge clock);
      csr_write <= 1'b0;
      norms_board.set_register(CSR_INV_SPACING, inv);
      norms_board.set_register(CSR_EPSILON, eps);
      @(posedge clock);
   endtask

   initial begin
      logic [CSR_W-1:0] inv;
      logic [CSR_W-1:0] eps;
      reset          = 1'b1;
      start          = 1'b0;
      csr_write      = 1'b0;
      csr_index      = CSR_INV_SPACING;
      csr_wdata      = '0;
      req_center     = '0;
      req_east       = '0;
      req_west       = '0;
      req_north      = '0;
      req_south      = '0;
      req_north_east = '0;
      req_north_west = '0;
      req_south_east = '0;
      req_south_west = '0;
      repeat (11)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners at the reset setting (h = 1, no epsilon)
      put_window(make_window(0, 0, 0, 0, 0, 0, 0, 0, 0));
      put_window(make_window(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      put_window(make_window(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                             -32768, -32768));
      put_window(make_window(32767, -32768, -32768, -32768, -32768, -32768, -32768,
                             -32768, -32768));
      put_window(make_window(-32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      // largest along step, east edge lands exactly on full scale
      put_window(make_window(-32768, 32767, 0, 0, 0, 0, 0, 0, 0));
      put_window(make_window(-32768, 32767, 0, 0, 0, 1, 0, 0, 0));
      put_window(make_window(-32768, 0, 32767, 0, 0, 0, 0, 0, 0));
      put_window(make_window(0, 0, 0, 32767, -32768, 0, 0, 0, 0));
      // largest cross sums, one edge at a time, plus north and south together
      put_window(make_window(0, 0, 0, 32767, -32768, 32767, 0, -32768, 0));
      put_window(make_window(0, 0, 0, 32767, -32768, 0, 32767, 0, -32768));
      put_window(make_window(0, 32767, -32768, 0, 0, 32767, -32768, 0, 0));
      put_window(make_window(0, 32767, -32768, 0, 0, 0, 0, 32767, -32768));
      put_window(make_window(-32768, 32767, -32768, 32767, -32768, 32767, -32768,
                             32767, -32768));
      // smallest nonzero gradients and a plain ramp
      put_window(make_window(0, 1, 0, 0, 0, 0, 0, 0, 0));
      put_window(make_window(1, 0, 0, 0, 0, 0, 0, 0, 0));
      put_window(make_window(4096, 8192, 0, 4096, 4096, 8192, 0, 8192, 0));
      put_window(make_window(100, -100, 300, -7, 12, 2000, -2000, 55, -55));
      put_window(make_window(-1, -1, -1, -1, -1, -1, -1, -1, -1));
      put_window(make_window(21845, -21846, -21846, -21846, -21846, -21846, -21846,
                             -21846, -21846));
      wait_drained(2);

      // Random windows under several settings, extremes included
      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         case (setting)
            0:       begin inv = 1;     eps = 0;            end
            1:       begin inv = 65535; eps = 32'hFFFFFFFF; end
            2:       begin inv = 0;     eps = $urandom;     end  // zero spacing
            3:       begin inv = 256;   eps = $urandom;     end
            4:       begin inv = $urandom_range(1, 65535); eps = $urandom_range(0, 1 << 24); end
            5:       begin inv = $urandom_range(64, 1024);  eps = 0; end
            6:       begin inv = $urandom_range(0, 65535);  eps = $urandom; end
            default: begin inv = 256;   eps = 0;            end
         endcase
         program_setting(inv, eps);
         for (int i = 0; i < WINDOWS_PER_SETTING; i++) begin
            // hold off once mid-setting until the pipeline is empty
            if (setting == 3 && i == WINDOWS_PER_SETTING / 2)
               wait_drained(0);
            put_window(random_window());
         end
         wait_drained(2);
      end

      wait_drained(LATENCY + 4);
      if (norms_board.expected_norms_q.size() != 0)
         norms_board.report($sformatf("%0d beats never came back",
                                      norms_board.expected_norms_q.size()));
      if (norms_board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
